/* hdl/sbph_pkg.sv */
// Package for the spectrum bar peak-hold block: widths, register indexes,
// reset values and the log2 fraction table.
// No dependencies; every other file of the block refers to it by scoped name.
package sbph_pkg;

   localparam int unsigned HEIGHT_W    = 6;
   localparam int unsigned MAG_W       = 32;
   localparam int unsigned BIN_IN_W    = 6;
   localparam int unsigned SUM_W       = 12;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam int unsigned DEF_BINS      = 64;
   localparam int unsigned DEF_FRAC_BITS = 16;

   // Register indexes of the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] REG_GATE_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_HEIGHT     = 4'd1;

   localparam logic [HEIGHT_W-1:0] GATE_THRESHOLD_RESET = 6'd6;
   localparam logic [HEIGHT_W-1:0] MAX_HEIGHT_RESET     = 6'd56;

   // round(14 * log10(2) * 2^16) and the additive height offset.
   localparam int unsigned LOG_SCALE     = 276196;
   localparam int unsigned HEIGHT_OFFSET = 21;

   // Frame average: sum / 60, done as sum * 4370 >> 18 (exact for sums below 4096).
   localparam int unsigned AVG_DIVISOR = 60;
   localparam int unsigned AVG_RECIP   = 4370;
   localparam int unsigned AVG_SHIFT   = 18;

   localparam int unsigned LOG_FRAC_W = 16;

   typedef struct packed {
      logic load_s1;
      logic load_s2;
   } pipe_ctl_type;

   // round(65536 * log2(1 + k/16))
   function automatic logic [LOG_FRAC_W-1:0] log2_frac(input logic [3:0] k);
      logic [LOG_FRAC_W-1:0] r;
      case (k)
         4'd0:    r = 16'd0;
         4'd1:    r = 16'd5732;
         4'd2:    r = 16'd11136;
         4'd3:    r = 16'd16248;
         4'd4:    r = 16'd21098;
         4'd5:    r = 16'd25711;
         4'd6:    r = 16'd30109;
         4'd7:    r = 16'd34312;
         4'd8:    r = 16'd38336;
         4'd9:    r = 16'd42196;
         4'd10:   r = 16'd45903;
         4'd11:   r = 16'd49472;
         4'd12:   r = 16'd52911;
         4'd13:   r = 16'd56228;
         4'd14:   r = 16'd59434;
         default: r = 16'd62534;
      endcase
      return r;
   endfunction

endpackage

/* hdl/sbph_if.sv */
// Channel interfaces of the spectrum bar peak-hold block: bin input,
// result output and configuration write. Depends on sbph_pkg for widths.
interface sbph_req_if;
   logic                             valid;
   logic                             ready;
   logic                             channel;
   logic [sbph_pkg::BIN_IN_W-1:0]    bin_index;
   logic [sbph_pkg::MAG_W-1:0]       magnitude;
   logic                             frame_end;

   modport source(output valid, channel, bin_index, magnitude, frame_end, input ready);
   modport sink(input valid, channel, bin_index, magnitude, frame_end, output ready);
endinterface

interface sbph_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sbph_pkg::HEIGHT_W-1:0]    bar_height;
   logic [sbph_pkg::HEIGHT_W-1:0]    peak_marker;
   logic                             gate_on;
   logic [sbph_pkg::HEIGHT_W-1:0]    frame_average;

   modport source(output valid, bar_height, peak_marker, gate_on, frame_average,
                  input ready);
   modport sink(input valid, bar_height, peak_marker, gate_on, frame_average,
                output ready);
endinterface

interface sbph_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sbph_pkg::CSR_INDEX_W-1:0] index;
   logic [sbph_pkg::CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* hdl/sbph_log_unit.sv */
// Two-stage logarithmic height unit: leading-one detect and table lookup,
// then the scale multiply, offset and clamp. Depends on sbph_pkg.
module sbph_log_unit #(
   parameter int unsigned FRAC_BITS = sbph_pkg::DEF_FRAC_BITS
) (
   input  logic                            clock,
   input  sbph_pkg::pipe_ctl_type          ctl,
   input  logic [sbph_pkg::MAG_W-1:0]      magnitude,
   input  logic [sbph_pkg::HEIGHT_W-1:0]   max_height,
   output logic [sbph_pkg::HEIGHT_W-1:0]   height
);

   localparam int unsigned EXP_W  = 7;
   localparam int unsigned L_W    = EXP_W + sbph_pkg::LOG_FRAC_W;
   localparam int unsigned SCL_W  = 20;
   localparam int unsigned PROD_W = L_W + SCL_W;
   localparam int unsigned HI_W   = PROD_W - 32;
   localparam int unsigned RAW_W  = 12;

   localparam logic signed [SCL_W-1:0] SCALE = SCL_W'(sbph_pkg::LOG_SCALE);

   logic [4:0]                    lead_pos;
   logic [sbph_pkg::MAG_W+3:0]    mag_ext;
   logic [3:0]                    mant;
   logic signed [EXP_W-1:0]       expo;
   logic signed [L_W-1:0]         log_in;

   logic                          zero_ff;
   logic                          zero_in;
   logic signed [L_W-1:0]         log_ff;

   logic signed [PROD_W-1:0]      prod;
   logic signed [RAW_W-1:0]       raw;
   logic [sbph_pkg::HEIGHT_W-1:0] height_ff;
   logic [sbph_pkg::HEIGHT_W-1:0] height_in;

   // Stage 1: position of the leading one and the four bits below it.
   always_comb begin
      lead_pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (magnitude[i]) begin
            lead_pos = 5'(i);
         end
      end
      mag_ext = {magnitude, 4'b0000};
      mant    = mag_ext[lead_pos +: 4];
      expo    = $signed(EXP_W'(lead_pos)) - $signed(EXP_W'(FRAC_BITS));
      // The table value stays below 2^16, so the sum is a plain concatenation.
      log_in  = {expo, sbph_pkg::log2_frac(mant)};
      zero_in = (magnitude == '0);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         zero_ff <= zero_in;
         log_ff  <= log_in;
      end
   end

   // Stage 2: the offset of 21 * 2^32 touches only the upper word of the product.
   // The upper word is signed, so it is sign-extended before the offset is added.
   always_comb begin
      prod = log_ff * SCALE;
      raw  = RAW_W'($signed(prod[PROD_W-1:PROD_W-HI_W]))
           + RAW_W'(sbph_pkg::HEIGHT_OFFSET);
      if (zero_ff || raw < 0) begin
         height_in = '0;
      end else if (raw > $signed({6'b0, max_height})) begin
         height_in = max_height;
      end else begin
         height_in = raw[sbph_pkg::HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s2) begin
         height_ff <= height_in;
      end
   end

   assign height = height_ff;

endmodule

/* hdl/spectrum_bar_peak_hold.sv */
// Spectrum bar with peak hold: log height, noise gate, per-bin peak memory.
// An accepted bin passes the s1, s2, s3 and output registers; one bin per cycle
// unless rsp ready is low or the clearing pass runs. The rate is set by the peak
// memory read-modify-write, forwarding the previous write into the next read. After
// reset a clearing pass zeroes the 2*BINS (default 128) entries, req ready held low.
// Depends on sbph_pkg, sbph_if and sbph_log_unit.
module spectrum_bar_peak_hold #(
   parameter int unsigned BINS      = sbph_pkg::DEF_BINS,
   parameter int unsigned FRAC_BITS = sbph_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   sbph_req_if.sink    req_if,
   sbph_rsp_if.source  rsp_if,
   sbph_csr_if.sink    csr_if
);

   localparam int unsigned DEPTH  = 2 * BINS;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned HW     = sbph_pkg::HEIGHT_W;
   localparam int unsigned SW     = sbph_pkg::SUM_W;
   localparam int unsigned LIM_W  = SW + 1;
   localparam int unsigned AVG_W  = SW + 13;

   localparam logic [LIM_W-1:0] LIMIT_RESET =
      LIM_W'(sbph_pkg::AVG_DIVISOR * (sbph_pkg::GATE_THRESHOLD_RESET + 1));
   localparam logic [LIM_W-1:0] LIMIT_NEVER = LIM_W'(1 << SW);

   sbph_pkg::pipe_ctl_type ctl;

   // Pipeline control
   logic              s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic              out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;
   logic              req_acc;

   // Sideband per stage
   logic              s1_ch_ff, s2_ch_ff, s3_ch_ff;
   logic              s1_fend_ff, s2_fend_ff, s3_fend_ff;
   logic [ADDR_W-1:0] s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic [ADDR_W-1:0] s1_addr_in;
   logic [HW-1:0]     s2_height;
   logic [HW-1:0]     s3_height_ff;

   // Configuration
   logic [HW-1:0]     max_height_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic [HW-1:0]     thr_data;

   // Peak memory and clearing pass
   logic [HW-1:0]     peak_mem [DEPTH];
   logic [HW-1:0]     peak_rd_ff;
   logic              byp_hit_ff;
   logic [HW-1:0]     byp_data_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [HW-1:0]     mem_wdata;

   // Commit stage
   logic              gate_ff;
   logic [SW-1:0]     sum_ff;
   logic [HW-1:0]     gated;
   logic [HW-1:0]     old_peak;
   logic [HW-1:0]     peak_max;
   logic [HW-1:0]     peak_new;
   logic [SW:0]       sum_add;
   logic [SW-1:0]     sum_new;
   logic              gate_off;
   logic [AVG_W-1:0]  avg_prod;
   logic [HW:0]       avg_raw;
   logic [HW-1:0]     avg;

   // Output register
   logic [HW-1:0]     out_height_ff;
   logic [HW-1:0]     out_peak_ff;
   logic              out_gate_ff;
   logic [HW-1:0]     out_avg_ff;

   // Bin numbers at or above BINS wrap; eight subtracts cover any 6-bit input if BINS >= 8.
   function automatic logic [sbph_pkg::BIN_IN_W-1:0] wrap_bin(
      input logic [sbph_pkg::BIN_IN_W-1:0] b
   );
      logic [sbph_pkg::BIN_IN_W-1:0] v;
      v = b;
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= BINS) begin
            v = v - sbph_pkg::BIN_IN_W'(BINS);
         end
      end
      return v;
   endfunction

   // Handshake chain
   always_comb begin
      out_free = !out_v_ff || rsp_if.ready;
      s3_go    = s3_v_ff && out_free;
      s3_free  = !s3_v_ff || s3_go;
      s2_go    = s2_v_ff && s3_free;
      s2_free  = !s2_v_ff || s2_go;
      s1_go    = s1_v_ff && s2_free;
      s1_free  = !s1_v_ff || s1_go;
   end

   assign req_if.ready = s1_free && !clr_busy_ff;
   assign req_acc      = req_if.valid && req_if.ready;
   assign ctl.load_s1  = req_acc;
   assign ctl.load_s2  = s1_go;
   assign csr_if.ready = 1'b1;

   assign s1_addr_in = ADDR_W'(wrap_bin(req_if.bin_index))
                     + (req_if.channel ? ADDR_W'(BINS) : ADDR_W'(0));

   sbph_log_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_log (
      .clock      (clock),
      .ctl        (ctl),
      .magnitude  (req_if.magnitude),
      .max_height (max_height_ff),
      .height     (s2_height)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_v_ff <= req_acc;
         end
         if (s2_free) begin
            s2_v_ff <= s1_go;
         end
         if (s3_free) begin
            s3_v_ff <= s2_go;
         end
         if (out_free) begin
            out_v_ff <= s3_go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_ch_ff   <= req_if.channel;
         s1_fend_ff <= req_if.frame_end;
         s1_addr_ff <= s1_addr_in;
      end
      if (s1_go) begin
         s2_ch_ff   <= s1_ch_ff;
         s2_fend_ff <= s1_fend_ff;
         s2_addr_ff <= s1_addr_ff;
      end
      if (s2_go) begin
         s3_ch_ff     <= s2_ch_ff;
         s3_fend_ff   <= s2_fend_ff;
         s3_addr_ff   <= s2_addr_ff;
         s3_height_ff <= s2_height;
      end
   end

   // Configuration registers
   assign thr_data = csr_if.data[HW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         max_height_ff <= sbph_pkg::MAX_HEIGHT_RESET;
         limit_ff      <= LIMIT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         unique case (csr_if.index)
            sbph_pkg::REG_GATE_THRESHOLD: begin
               // The gate turns off when the sum reaches 60 * (threshold + 1);
               // a threshold of 63 can never be exceeded by the saturated average.
               if (thr_data == '1) begin
                  limit_ff <= LIMIT_NEVER;
               end else begin
                  limit_ff <= LIM_W'(({1'b0, thr_data} + 7'd1) * sbph_pkg::AVG_DIVISOR);
               end
            end
            sbph_pkg::REG_MAX_HEIGHT: begin
               max_height_ff <= thr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign mem_we    = clr_busy_ff || s3_go;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : s3_addr_ff;
   assign mem_wdata = clr_busy_ff ? '0 : peak_new;

   // The read for the next item happens on the edge where the current item
   // writes back; a write to the same entry on that edge is forwarded.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         peak_mem[mem_waddr] <= mem_wdata;
      end
      if (s2_go) begin
         peak_rd_ff  <= peak_mem[s2_addr_ff];
         byp_hit_ff  <= s3_go && (s3_addr_ff == s2_addr_ff);
         byp_data_ff <= peak_new;
      end
   end

   // Commit stage: gate, peak update, running sum and frame close
   always_comb begin
      gated = s3_height_ff;
      if (gate_ff) begin
         case (s3_height_ff) inside
            [6'd10:6'd20]: gated = s3_height_ff >> 1;
            6'd5:          gated = 6'd2;
            6'd6:          gated = 6'd3;
            [6'd7:6'd8]:   gated = 6'd4;
            6'd9:          gated = 6'd5;
            [6'd0:6'd4]:   gated = 6'd0;
            default:       gated = s3_height_ff;
         endcase
      end

      old_peak = byp_hit_ff ? byp_data_ff : peak_rd_ff;
      peak_max = (old_peak < gated) ? gated : old_peak;
      peak_new = (peak_max != '0) ? peak_max - HW'(1) : peak_max;

      sum_add = {1'b0, sum_ff} + (SW + 1)'(gated);
      if (s3_ch_ff) begin
         sum_new = sum_ff;
      end else if (sum_add[SW]) begin
         sum_new = '1;
      end else begin
         sum_new = sum_add[SW-1:0];
      end

      gate_off = ({1'b0, sum_new} >= limit_ff);

      avg_prod = AVG_W'(sum_new) * AVG_W'(sbph_pkg::AVG_RECIP);
      avg_raw  = avg_prod[sbph_pkg::AVG_SHIFT +: (HW + 1)];
      avg      = avg_raw[HW] ? '1 : avg_raw[HW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff <= 1'b1;
         sum_ff  <= '0;
      end else if (s3_go) begin
         if (s3_fend_ff) begin
            gate_ff <= !gate_off;
            sum_ff  <= '0;
         end else begin
            sum_ff  <= sum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go) begin
         out_height_ff <= gated;
         out_peak_ff   <= old_peak;
         out_gate_ff   <= gate_ff;
         out_avg_ff    <= s3_fend_ff ? avg : '0;
      end
   end

   assign rsp_if.valid         = out_v_ff;
   assign rsp_if.bar_height    = out_height_ff;
   assign rsp_if.peak_marker   = out_peak_ff;
   assign rsp_if.gate_on       = out_gate_ff;
   assign rsp_if.frame_average = out_avg_ff;

endmodule
